// File: rtl/mfhp_pkg.sv
// shared types, constants and rate tables for the mp3 frame header parser
package mfhp_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSYNC  = 3'd1,
      ST_VERSION = 3'd2,
      ST_LAYER   = 3'd3,
      ST_BITRATE = 3'd4,
      ST_RATE    = 3'd5,
      ST_TRUNC   = 3'd6
   } status_type;

   // parse phases
   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_HAVE1  = 2'd1,
      PH_HAVE2  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // header field codes
   localparam logic [1:0] VER_MPEG25   = 2'b00;
   localparam logic [1:0] VER_RESERVED = 2'b01;
   localparam logic [1:0] VER_MPEG2    = 2'b10;
   localparam logic [1:0] VER_MPEG1    = 2'b11;
   localparam logic [1:0] LAYER_III    = 2'b01;
   localparam logic [1:0] SIDX_RESERVED = 2'b11;
   localparam logic [1:0] MODE_MONO    = 2'b11;
   localparam logic [7:0] SYNC_BYTE    = 8'hFF;
   localparam logic [2:0] SYNC_TOP     = 3'b111;

   // widths of the block size division
   localparam int KbpsW = 9;
   localparam int DenW  = 16;
   localparam int NumW  = 26;
   localparam int QuotW = 12;
   localparam int CntW  = $clog2(NumW + 1);
   // numerator is kbps * 9 * 2^14 (147456 = 9 << 14)
   localparam int NumShift = 14;

   typedef logic [KbpsW-1:0] kbps_type;

   // kbit/s by bitrate index, zero marks an invalid index
   localparam kbps_type KBPS_V1 [16] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0 };
   localparam kbps_type KBPS_V2 [16] = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0 };

   // bitrate lookup by version and index
   function automatic kbps_type kbps_lookup(input logic [1:0] version,
                                            input logic [3:0] idx);
      kbps_lookup = (version == VER_MPEG1) ? KBPS_V1[idx] : KBPS_V2[idx];
   endfunction

   // sampling rate lookup in hertz, zero for reserved codes
   function automatic logic [DenW-1:0] fs_lookup(input logic [1:0] version,
                                                 input logic [1:0] sidx);
      logic [DenW-1:0] fs;
      fs = '0;
      unique case (sidx)
         2'd0: begin
            unique case (version)
               VER_MPEG25: fs = 16'd11025;
               VER_MPEG2:  fs = 16'd22050;
               VER_MPEG1:  fs = 16'd44100;
               default:    fs = '0;
            endcase
         end
         2'd1: begin
            unique case (version)
               VER_MPEG25: fs = 16'd12000;
               VER_MPEG2:  fs = 16'd24000;
               VER_MPEG1:  fs = 16'd48000;
               default:    fs = '0;
            endcase
         end
         2'd2: begin
            unique case (version)
               VER_MPEG25: fs = 16'd8000;
               VER_MPEG2:  fs = 16'd16000;
               VER_MPEG1:  fs = 16'd32000;
               default:    fs = '0;
            endcase
         end
         default: fs = '0;
      endcase
      fs_lookup = fs;
   endfunction

endpackage

// File: rtl/mfhp_divider.sv
// bit-serial restoring divider for the block size, one quotient bit per cycle
module mfhp_divider
   import mfhp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NumW-1:0]  numer,
   input  logic [DenW-1:0]  denom,
   output logic             done,
   output logic [QuotW-1:0] quotient
);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [NumW-1:0]  num_ff, num_in;
   logic [DenW-1:0]  den_ff, den_in;
   logic [DenW-1:0]  rem_ff, rem_in;
   logic [QuotW-1:0] quo_ff, quo_in;

   logic [DenW:0]    shifted;
   logic [DenW:0]    diff;
   logic             fits;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, num_ff[NumW-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
   end

   // next values of the shift registers and counter
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CntW'(NumW);
         num_in    = numer;
         den_in    = denom;
         rem_in    = '0;
         quo_in    = '0;
      end else if (active_ff) begin
         cnt_in = cnt_ff - 1'b1;
         num_in = {num_ff[NumW-2:0], 1'b0};
         rem_in = fits ? diff[DenW-1:0] : shifted[DenW-1:0];
         quo_in = {quo_ff[QuotW-2:0], fits};
         if (cnt_ff == CntW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/mp3_frame_header_parser.sv
// mp3 frame header parser top level: byte scanner, header checks, result register
//
// The req channel takes one buffer byte per transaction with a mark on the
// final byte. The block scans for the first frame sync, captures the header
// and gives exactly one rsp transaction per buffer: the decoded header, or
// the first failure found. Bytes after that result are ignored until the
// final byte of the buffer, which rearms the scanner.
// Throughput is one byte per cycle while scanning, unless the divider or a pending
// result holds req_ready low. Failures and end-of-buffer results are registered
// and appear in the cycle after the byte that caused them. A complete header
// starts the bit-serial block size divider; req_ready stays low until its done
// flag loads the result register. A pending result does not block bytes once
// the buffer is past its header; otherwise a new byte is taken only when the
// result register is free or drains in the same cycle, so a stalled receiver
// stalls the sender.
// Synchronous reset clears the scanner, the divider and the result register.
module mp3_frame_header_parser
   import mfhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_channel_count,
   output logic [15:0] rsp_sample_rate,
   output logic [15:0] rsp_avg_bytes_per_sec,
   output logic [11:0] rsp_block_size
);

   phase_type        phase_ff, phase_in, step_phase;
   logic [7:0]       prev_byte_ff;
   logic             prev_valid_ff;
   logic [7:0]       hdr1_ff;
   logic [7:0]       hdr2_ff;
   logic             busy_ff;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [1:0]       rsp_ch_ff;
   logic [DenW-1:0]  rsp_fs_ff;
   logic [15:0]      rsp_bps_ff;
   logic [QuotW-1:0] rsp_blk_ff;

   logic             accept;
   logic             sync_hit, ver_bad, layer_bad, br_bad, rate_bad;
   logic             fail_emit, eof_emit, res_emit, start_div;
   status_type       res_status;

   kbps_type         ok_kbps;
   logic [DenW-1:0]  ok_fs;
   logic [1:0]       ok_ch;
   logic [11:0]      kbps_x9;
   logic [NumW-1:0]  div_numer;
   logic             div_done;
   logic [QuotW-1:0] div_quot;

   // input handshake: after the header no result can come, so a pending one never blocks
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready || phase_ff == PH_DONE);
   assign accept    = req_valid && req_ready;

   // header field checks on the incoming byte
   always_comb begin
      sync_hit  = prev_valid_ff && (prev_byte_ff == SYNC_BYTE)
                  && (req_data_byte[7:5] == SYNC_TOP);
      ver_bad   = (req_data_byte[4:3] == VER_RESERVED);
      layer_bad = (req_data_byte[2:1] != LAYER_III);
      br_bad    = (kbps_lookup(hdr1_ff[4:3], req_data_byte[7:4]) == '0);
      rate_bad  = (req_data_byte[3:2] == SIDX_RESERVED);
   end

   // next phase
   always_comb begin
      step_phase = phase_ff;
      unique case (phase_ff)
         PH_SEARCH: begin
            if (sync_hit) step_phase = (ver_bad || layer_bad) ? PH_DONE : PH_HAVE1;
         end
         PH_HAVE1: step_phase = (br_bad || rate_bad) ? PH_DONE : PH_HAVE2;
         PH_HAVE2: step_phase = PH_DONE;
         PH_DONE:  step_phase = PH_DONE;
         default:  step_phase = PH_SEARCH;
      endcase
      phase_in = phase_ff;
      if (accept) phase_in = req_last_byte ? PH_SEARCH : step_phase;
   end

   // result decoding for the current byte
   always_comb begin
      fail_emit  = 1'b0;
      start_div  = 1'b0;
      res_status = ST_OK;
      unique case (phase_ff)
         PH_SEARCH: begin
            priority if (sync_hit && ver_bad) begin
               fail_emit  = 1'b1;
               res_status = ST_VERSION;
            end else if (sync_hit && layer_bad) begin
               fail_emit  = 1'b1;
               res_status = ST_LAYER;
            end else begin
               fail_emit  = 1'b0;
            end
         end
         PH_HAVE1: begin
            priority if (br_bad) begin
               fail_emit  = 1'b1;
               res_status = ST_BITRATE;
            end else if (rate_bad) begin
               fail_emit  = 1'b1;
               res_status = ST_RATE;
            end else begin
               fail_emit  = 1'b0;
            end
         end
         PH_HAVE2: start_div = 1'b1;
         default:  start_div = 1'b0;
      endcase
      eof_emit = req_last_byte && !fail_emit && !start_div && (step_phase != PH_DONE);
      if (eof_emit) res_status = (step_phase == PH_SEARCH) ? ST_NOSYNC : ST_TRUNC;
      res_emit = fail_emit || eof_emit;
   end

   // decoded fields of a complete header
   always_comb begin
      ok_kbps   = kbps_lookup(hdr1_ff[4:3], hdr2_ff[7:4]);
      ok_fs     = fs_lookup(hdr1_ff[4:3], hdr2_ff[3:2]);
      ok_ch     = (req_data_byte[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
      kbps_x9   = {ok_kbps, 3'b000} + {3'b000, ok_kbps};
      div_numer = {kbps_x9, {NumShift{1'b0}}};
   end

   // block size divider
   mfhp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && start_div),
      .numer    (div_numer),
      .denom    (ok_fs),
      .done     (div_done),
      .quotient (div_quot)
   );

   // scanner and result control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEARCH;
         prev_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (accept) prev_valid_ff <= !req_last_byte;
         if ((accept && res_emit) || div_done) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (div_done) busy_ff <= 1'b0;
         else if (accept && start_div) busy_ff <= 1'b1;
      end
   end

   // byte history, header bytes and result payload
   always_ff @(posedge clock) begin
      if (accept) prev_byte_ff <= req_data_byte;
      if (accept && phase_ff == PH_SEARCH && sync_hit) hdr1_ff <= req_data_byte;
      if (accept && phase_ff == PH_HAVE1) hdr2_ff <= req_data_byte;
      if (accept && res_emit) begin
         rsp_status_ff <= res_status;
         rsp_ch_ff     <= '0;
         rsp_fs_ff     <= '0;
         rsp_bps_ff    <= '0;
         rsp_blk_ff    <= '0;
      end
      if (accept && start_div) begin
         rsp_status_ff <= ST_OK;
         rsp_ch_ff     <= ok_ch;
         rsp_fs_ff     <= ok_fs;
         rsp_bps_ff    <= {ok_kbps, 7'b0000000};
      end
      if (div_done) rsp_blk_ff <= div_quot;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_channel_count     = rsp_ch_ff;
   assign rsp_sample_rate       = rsp_fs_ff;
   assign rsp_avg_bytes_per_sec = rsp_bps_ff;
   assign rsp_block_size        = rsp_blk_ff;

   // no byte is taken while the divider runs
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready)
      else $error("byte accepted during block size division");

   // the result register stays empty while the divider runs
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !rsp_valid_ff)
      else $error("result pending during block size division");

   // divider completion only for a started header
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> busy_ff)
      else $error("divider finished without a header");

   // a failure result carries zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |->
         (rsp_fs_ff == '0 && rsp_ch_ff == '0 && rsp_blk_ff == '0))
      else $error("failure result with nonzero fields");

endmodule
